FILE: rtl/s1kd_pkg.sv
// Package: shared constants and decode functions for the set-1 key decoder.
package s1kd_pkg;

  // Field widths
  localparam int unsigned ScanW = 8;
  localparam int unsigned KeyW  = 7;
  localparam int unsigned ModW  = 6;
  localparam int unsigned LockW = 3;

  // Stream widths: tdata carries key_code, modifiers, lock_mask, led_update
  localparam int unsigned OutFieldW = KeyW + ModW + LockW + 1;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Special scan codes
  localparam logic [ScanW-1:0] ExtPrefix = 8'hE0;
  localparam logic [KeyW-1:0]  PlainMax  = 7'd88;
  localparam logic [KeyW-1:0]  ExtBase   = 7'd89;
  localparam logic [KeyW-1:0]  KeyMax    = 7'd103;
  localparam logic [KeyW-1:0]  KeyNone   = 7'd0;

  // Modifier and lock keys (standard set 1)
  localparam logic [KeyW-1:0] KeyLShift = 7'h2A;
  localparam logic [KeyW-1:0] KeyRShift = 7'h36;
  localparam logic [KeyW-1:0] KeyLCtrl  = 7'h1D;
  localparam logic [KeyW-1:0] KeyLAlt   = 7'h38;
  localparam logic [KeyW-1:0] KeyCaps   = 7'h3A;
  localparam logic [KeyW-1:0] KeyNum    = 7'h45;
  localparam logic [KeyW-1:0] KeyScroll = 7'h46;
  localparam logic [KeyW-1:0] KeyRCtrl  = 7'd90;
  localparam logic [KeyW-1:0] KeyRAlt   = 7'd92;

  // Lock bits
  localparam logic [LockW-1:0] LockScroll = 3'b001;
  localparam logic [LockW-1:0] LockNum    = 3'b010;
  localparam logic [LockW-1:0] LockCaps   = 3'b100;

  // Map an extended code (after the prefix) to key codes 89..103, else none
  function automatic logic [KeyW-1:0] map_extended(input logic [KeyW-1:0] code);
    logic [KeyW-1:0] idx;
    logic            hit;
    idx = '0;
    hit = 1'b1;
    case (code)
      7'h1C:   idx = 7'd0;
      7'h1D:   idx = 7'd1;
      7'h35:   idx = 7'd2;
      7'h38:   idx = 7'd3;
      7'h47:   idx = 7'd4;
      7'h48:   idx = 7'd5;
      7'h50:   idx = 7'd6;
      7'h4D:   idx = 7'd7;
      7'h4B:   idx = 7'd8;
      7'h49:   idx = 7'd9;
      7'h51:   idx = 7'd10;
      7'h52:   idx = 7'd11;
      7'h53:   idx = 7'd12;
      7'h4F:   idx = 7'd13;
      7'h5D:   idx = 7'd14;
      default: hit = 1'b0;
    endcase
    return hit ? (ExtBase + idx) : KeyNone;
  endfunction

  // Modifier flag bit of a key code
  function automatic logic [ModW-1:0] modifier_bit(input logic [KeyW-1:0] key);
    logic [ModW-1:0] mbit;
    case (key)
      KeyLShift: mbit = 6'b000001;
      KeyRShift: mbit = 6'b000010;
      KeyLCtrl:  mbit = 6'b000100;
      KeyRCtrl:  mbit = 6'b001000;
      KeyLAlt:   mbit = 6'b010000;
      KeyRAlt:   mbit = 6'b100000;
      default:   mbit = '0;
    endcase
    return mbit;
  endfunction

  // Lock flag bit of a key code
  function automatic logic [LockW-1:0] lock_bit(input logic [KeyW-1:0] key);
    logic [LockW-1:0] lbit;
    case (key)
      KeyScroll: lbit = LockScroll;
      KeyNum:    lbit = LockNum;
      KeyCaps:   lbit = LockCaps;
      default:   lbit = '0;
    endcase
    return lbit;
  endfunction

endpackage

FILE: rtl/scancode_set1_key_decoder.sv
// Set-1 scan code decoder: byte register, one-pass decode, result register.
// Path: a taken byte is held in the input register, then decoded into the result register.
// Throughput: one byte per cycle; the input register and the result register
// form a two-deep pipeline that stalls only while the result is not taken.
// Reset: clears the extended flag, all modifier and lock flags and both valids.
module scancode_set1_key_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [s1kd_pkg::ScanW-1:0]     s_axis_tdata_i,  // [7:0] scan_code
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [6:0] key_code, [12:7] modifiers, [15:13] lock_mask, [16] led_update,
  // [23:17] zero
  output logic [s1kd_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tuser_o   // [0] released
);

  // Input stage
  logic                          in_vld_q;
  logic [s1kd_pkg::ScanW-1:0]    in_byte_q;
  // Decoder state
  logic                          ext_q, ext_d;
  logic [s1kd_pkg::ModW-1:0]     mod_q, mod_d;
  logic [s1kd_pkg::LockW-1:0]    lock_q, lock_d;
  // Result stage
  logic                          out_vld_q;
  logic [s1kd_pkg::KeyW-1:0]     key_q, key_d;
  logic                          rel_q, rel_d;
  logic                          led_q, led_d;

  logic                          advance;
  logic                          in_take;
  logic [s1kd_pkg::KeyW-1:0]     code;
  logic [s1kd_pkg::ModW-1:0]     mbit;
  logic [s1kd_pkg::LockW-1:0]    lbit;

  // Move the held byte into the result stage when that stage is free
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Decode one byte against the current state
  always_comb begin
    code   = in_byte_q[s1kd_pkg::KeyW-1:0];
    ext_d  = ext_q;
    mod_d  = mod_q;
    lock_d = lock_q;
    key_d  = s1kd_pkg::KeyNone;
    rel_d  = 1'b0;
    led_d  = 1'b0;
    mbit   = '0;
    lbit   = '0;
    if (in_byte_q == s1kd_pkg::ExtPrefix) begin
      ext_d = 1'b1;
    end else begin
      rel_d = in_byte_q[s1kd_pkg::ScanW-1];
      if (ext_q) begin
        key_d = s1kd_pkg::map_extended(code);
      end else if (code <= s1kd_pkg::PlainMax) begin
        key_d = code;
      end
      ext_d = 1'b0;
      mbit  = s1kd_pkg::modifier_bit(key_d);
      lbit  = s1kd_pkg::lock_bit(key_d);
      if (rel_d) begin
        mod_d = mod_q & ~mbit;
      end else if (key_d != s1kd_pkg::KeyNone) begin
        mod_d = mod_q | mbit;
        if (lbit != '0) begin
          lock_d = lock_q ^ lbit;
          led_d  = 1'b1;
        end
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ext_q     <= 1'b0;
      mod_q     <= '0;
      lock_q    <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        ext_q     <= ext_d;
        mod_q     <= mod_d;
        lock_q    <= lock_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      key_q <= key_d;
      rel_q <= rel_d;
      led_q <= led_d;
    end
  end

  // Drive the result channel; flags shown are those held after the byte
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = rel_q;
  assign m_axis_tdata_o  = {{(s1kd_pkg::OutDataW - s1kd_pkg::OutFieldW){1'b0}},
                            led_q, lock_q, mod_q, key_q};

  // A lock toggle comes only from the make of a lock key
  a_led_make: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && led_q |-> !rel_q && (s1kd_pkg::lock_bit(key_q) != '0))
    else $error("LED update without a lock key make");

  // Key codes stay in the decoded range
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> key_q <= s1kd_pkg::KeyMax)
    else $error("key code out of range");

  // A modifier break leaves its flag clear
  a_mod_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && rel_q |-> (mod_q & s1kd_pkg::modifier_bit(key_q)) == '0)
    else $error("modifier still held after its break");

  // A modifier make leaves its flag set
  a_mod_make: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rel_q |->
      (mod_q & s1kd_pkg::modifier_bit(key_q)) == s1kd_pkg::modifier_bit(key_q))
    else $error("modifier not held after its make");

  // Lock state changes only on a transfer that raises an LED update
  a_lock_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q != $past(lock_q) |-> out_vld_q && led_q)
    else $error("lock flags changed without an LED update");

endmodule
